// ===== hw/rtl/bsl_pkg.sv =====
// ----------------------------------------------------------------------------
// Button press detector package
// Shared constants, types and helpers for the short/long press detector.
// ----------------------------------------------------------------------------
package bsl_pkg;

  localparam int BUTTON_COUNT = 5;
  localparam int TIME_WIDTH   = 16;

  // Fixed widths of the channel fields and configuration registers.
  localparam int MS_W    = 16;
  localparam int MASK_W  = 5;
  localparam int CIDX_W  = 3;

  // Counters and thresholds are compared at a common width.
  localparam int CMP_W = (TIME_WIDTH > MS_W) ? TIME_WIDTH : MS_W;
  localparam int SUM_W = CMP_W + 1;

  localparam logic [MS_W-1:0]       SKIP_LIMIT = MS_W'(500);
  localparam logic [TIME_WIDTH-1:0] TIME_MAX   = {TIME_WIDTH{1'b1}};

  typedef logic [TIME_WIDTH-1:0] time_t;
  typedef logic [MS_W-1:0]       ms_t;
  typedef logic [MASK_W-1:0]     fmask_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_SHORT_MS   = 3'd0,
    CFG_LONG_MS    = 3'd1,
    CFG_RELEASE_MS = 3'd2,
    CFG_SHORT_EN   = 3'd3,
    CFG_LONG_EN    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    ms_t    short_ms;
    ms_t    long_ms;
    ms_t    release_ms;
    fmask_t short_en;
    fmask_t long_en;
  } bsl_cfg_t;

  typedef struct packed {
    logic short_set;
    logic long_set;
  } lane_evt_t;

  function automatic logic [CMP_W-1:0] ext_time(input time_t t);
    return CMP_W'(t);
  endfunction

  function automatic logic [CMP_W-1:0] ext_ms(input ms_t m);
    return CMP_W'(m);
  endfunction

  // Saturating add of a tick's elapsed time to a counter.
  function automatic time_t sat_add(input time_t a, input ms_t e);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(e);
    if (s > SUM_W'(TIME_MAX)) begin
      return TIME_MAX;
    end
    return s[TIME_WIDTH-1:0];
  endfunction

endpackage

// ===== hw/rtl/bsl_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the press thresholds and per-button enable masks.
// ----------------------------------------------------------------------------
module bsl_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [bsl_pkg::CIDX_W-1:0] cfg_index,
  input  logic [bsl_pkg::MS_W-1:0]  cfg_data,
  output bsl_pkg::bsl_cfg_t         cfg_o
);
  import bsl_pkg::*;

  bsl_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_ms   <= MS_W'(50);
      cfg_r.long_ms    <= MS_W'(1000);
      cfg_r.release_ms <= MS_W'(50);
      cfg_r.short_en   <= MASK_W'(31);
      cfg_r.long_en    <= MASK_W'(31);
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SHORT_MS:   cfg_r.short_ms   <= cfg_data;
        CFG_LONG_MS:    cfg_r.long_ms    <= cfg_data;
        CFG_RELEASE_MS: cfg_r.release_ms <= cfg_data;
        CFG_SHORT_EN:   cfg_r.short_en   <= cfg_data[MASK_W-1:0];
        CFG_LONG_EN:    cfg_r.long_en    <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/bsl_lane.sv =====
// ----------------------------------------------------------------------------
// Button lane
// Pressed and released time counters of one button and its press events.
// ----------------------------------------------------------------------------
module bsl_lane (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  upd_en,
  input  logic                  pressed,
  input  logic                  short_en,
  input  logic                  long_en,
  input  logic [bsl_pkg::MS_W-1:0] elapsed,
  input  bsl_pkg::bsl_cfg_t     cfg,
  output bsl_pkg::lane_evt_t    evt
);
  import bsl_pkg::*;

  time_t press_r, press_nxt;
  time_t rel_r, rel_nxt;
  logic  seen_r, seen_nxt;

  always_comb begin
    press_nxt     = press_r;
    rel_nxt       = rel_r;
    seen_nxt      = seen_r;
    evt.short_set = 1'b0;
    evt.long_set  = 1'b0;
    if (upd_en) begin
      if (pressed) begin
        if (ext_time(press_r) < ext_ms(cfg.long_ms)) begin
          press_nxt = sat_add(press_r, elapsed);
        end else if (long_en && seen_r) begin
          evt.long_set = 1'b1;
          seen_nxt     = 1'b0;
        end
        // Uses the pressed time after this tick's add.
        if (ext_time(press_nxt) > ext_ms(cfg.release_ms)) begin
          rel_nxt = '0;
        end
      end else begin
        if (ext_time(rel_r) < ext_ms(cfg.release_ms)) begin
          rel_nxt = sat_add(rel_r, elapsed);
        end else begin
          evt.short_set = short_en
                          && (ext_time(press_r) > ext_ms(cfg.short_ms))
                          && (!long_en || (ext_time(press_r) < ext_ms(cfg.long_ms)));
          seen_nxt  = 1'b1;
          press_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_r <= '0;
      rel_r   <= '0;
      seen_r  <= 1'b0;
    end else begin
      press_r <= press_nxt;
      rel_r   <= rel_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

// ===== hw/rtl/button_short_long_press_detector_core.sv =====
// An accepted tick waits in the input register, then its result in the result register.
// Throughput: one tick per cycle while out_stall is low; the input register feeds
// the lane update and the result register in the same cycle, so ticks follow back to back.
// Reset: synchronous, active low; counters and pending masks clear to zero
// and the thresholds return to their defaults.
// ----------------------------------------------------------------------------
// Button short/long press detector
// Input register, per-button lanes, pending masks and a result register.
// ----------------------------------------------------------------------------
module button_short_long_press_detector_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bsl_pkg::MS_W-1:0]    in_elapsed_ms,
  input  logic [bsl_pkg::MASK_W-1:0]  in_pressed_levels,
  input  logic                        in_take_short,
  input  logic                        in_take_long,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bsl_pkg::MASK_W-1:0]  out_short_mask,
  output logic [bsl_pkg::MASK_W-1:0]  out_long_mask,
  output logic                        out_tick_ok,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bsl_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [bsl_pkg::MS_W-1:0]    cfg_data
);
  import bsl_pkg::*;

  bsl_cfg_t cfg;

  // Input register
  logic   in_vld_r;
  ms_t    in_elapsed_r;
  fmask_t in_levels_r;
  logic   in_take_s_r, in_take_l_r;

  // Result register
  logic   out_valid_r;
  fmask_t out_short_r, out_long_r;
  logic   out_tick_ok_r;

  logic [BUTTON_COUNT-1:0] short_pend_r, short_pend_nxt;
  logic [BUTTON_COUNT-1:0] long_pend_r, long_pend_nxt;
  logic [BUTTON_COUNT-1:0] short_set, long_set;
  logic [BUTTON_COUNT-1:0] short_all, long_all;
  fmask_t                  short_cut, long_cut;

  logic in_accept, advance, tick_ok, upd_en;

  assign advance   = in_vld_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_vld_r && out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign tick_ok   = in_elapsed_r < SKIP_LIMIT;
  assign upd_en    = advance && tick_ok;

  bsl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  for (genvar b = 0; b < BUTTON_COUNT; b++) begin : g_lane
    logic      lvl, s_en, l_en;
    lane_evt_t evt;
    if (b < MASK_W) begin : g_map
      assign lvl  = in_levels_r[b];
      assign s_en = cfg.short_en[b];
      assign l_en = cfg.long_en[b];
    end else begin : g_zero
      assign lvl  = 1'b0;
      assign s_en = 1'b0;
      assign l_en = 1'b0;
    end
    bsl_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .upd_en   (upd_en),
      .pressed  (lvl),
      .short_en (s_en),
      .long_en  (l_en),
      .elapsed  (in_elapsed_r),
      .cfg      (cfg),
      .evt      (evt)
    );
    assign short_set[b] = evt.short_set;
    assign long_set[b]  = evt.long_set;
  end

  // Counters update before collection, so a beat sees its own new events.
  assign short_all = short_pend_r | short_set;
  assign long_all  = long_pend_r | long_set;

  for (genvar j = 0; j < MASK_W; j++) begin : g_cut
    if (j < BUTTON_COUNT) begin : g_bit
      assign short_cut[j] = short_all[j];
      assign long_cut[j]  = long_all[j];
    end else begin : g_pad
      assign short_cut[j] = 1'b0;
      assign long_cut[j]  = 1'b0;
    end
  end

  always_comb begin
    short_pend_nxt = short_pend_r;
    long_pend_nxt  = long_pend_r;
    if (advance) begin
      short_pend_nxt = in_take_s_r ? '0 : short_all;
      long_pend_nxt  = in_take_l_r ? '0 : long_all;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      short_pend_r <= '0;
      long_pend_r  <= '0;
    end else begin
      short_pend_r <= short_pend_nxt;
      long_pend_r  <= long_pend_nxt;
      if (in_accept) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_elapsed_r <= in_elapsed_ms;
      in_levels_r  <= in_pressed_levels;
      in_take_s_r  <= in_take_short;
      in_take_l_r  <= in_take_long;
    end
    if (advance) begin
      out_short_r   <= in_take_s_r ? short_cut : '0;
      out_long_r    <= in_take_l_r ? long_cut : '0;
      out_tick_ok_r <= tick_ok;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_short_mask = out_short_r;
  assign out_long_mask  = out_long_r;
  assign out_tick_ok    = out_tick_ok_r;

endmodule

// ===== bench/press_event_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Press event checker
// Watches the tick, result and register channels of the press detector. It
// keeps its own copy of the per-button counters and pending masks, predicts
// one result per accepted tick and compares every result beat in order.
// ----------------------------------------------------------------------------
module press_event_checker
  import bsl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  ms_t               in_elapsed_ms,
  input  fmask_t            in_pressed_levels,
  input  logic              in_take_short,
  input  logic              in_take_long,
  input  logic              out_valid,
  input  logic              out_stall,
  input  fmask_t            out_short_mask,
  input  fmask_t            out_long_mask,
  input  logic              out_tick_ok,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  ms_t               cfg_data,
  output int                fail_count,
  output int                open_beats
);

  typedef struct packed {
    fmask_t short_m;
    fmask_t long_m;
    logic   ok;
  } tick_result_t;

  bsl_cfg_t     thr;
  time_t        held_ms [BUTTON_COUNT];
  time_t        idle_ms [BUTTON_COUNT];
  fmask_t       short_pend;
  fmask_t       long_pend;
  fmask_t       rel_seen;
  tick_result_t result_q [$];
  int           errors = 0;

  assign fail_count = errors;

  task automatic report_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_error($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  function automatic time_t add_sat(input time_t a, input ms_t e);
    logic [TIME_WIDTH:0] s;
    s = {1'b0, a} + (TIME_WIDTH + 1)'(e);
    return s[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : s[TIME_WIDTH-1:0];
  endfunction

  // One tick: every lane is updated first, collection comes last.
  function automatic tick_result_t step_tick(input ms_t el, input fmask_t lv,
                                             input logic ts, input logic tl);
    tick_result_t r;
    r.ok = (el < SKIP_LIMIT);
    if (r.ok) begin
      for (int b = 0; b < BUTTON_COUNT; b++) begin
        if (lv[b]) begin
          if (held_ms[b] < thr.long_ms) begin
            held_ms[b] = add_sat(held_ms[b], el);
          end else if (thr.long_en[b] && rel_seen[b]) begin
            long_pend[b] = 1'b1;
            rel_seen[b]  = 1'b0;
          end
          if (held_ms[b] > thr.release_ms) begin
            idle_ms[b] = '0;
          end
        end else begin
          if (idle_ms[b] < thr.release_ms) begin
            idle_ms[b] = add_sat(idle_ms[b], el);
          end else begin
            // Debounced release: qualify a short press, then rearm the lane.
            if (thr.short_en[b] && held_ms[b] > thr.short_ms &&
                (!thr.long_en[b] || held_ms[b] < thr.long_ms)) begin
              short_pend[b] = 1'b1;
            end
            rel_seen[b] = 1'b1;
            held_ms[b]  = '0;
          end
        end
      end
    end
    r.short_m = ts ? short_pend : '0;
    r.long_m  = tl ? long_pend : '0;
    if (ts) begin
      short_pend = '0;
    end
    if (tl) begin
      long_pend = '0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    tick_result_t want;
    if (!rst_n) begin
      thr.short_ms   = 16'd50;
      thr.long_ms    = 16'd1000;
      thr.release_ms = 16'd50;
      thr.short_en   = '1;
      thr.long_en    = '1;
      for (int b = 0; b < BUTTON_COUNT; b++) begin
        held_ms[b] = '0;
        idle_ms[b] = '0;
      end
      short_pend = '0;
      long_pend  = '0;
      rel_seen   = '0;
      result_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SHORT_MS:   thr.short_ms = cfg_data;
          CFG_LONG_MS:    thr.long_ms = cfg_data;
          CFG_RELEASE_MS: thr.release_ms = cfg_data;
          CFG_SHORT_EN:   thr.short_en = cfg_data[MASK_W-1:0];
          CFG_LONG_EN:    thr.long_en = cfg_data[MASK_W-1:0];
          default: ;
        endcase
      end
      // The result leaving now belongs to an older tick than any entering now.
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          report_error("result beat with no tick outstanding");
        end else begin
          want = result_q.pop_front();
          check_field("short_mask", out_short_mask, want.short_m);
          check_field("long_mask", out_long_mask, want.long_m);
          check_field("tick_ok", out_tick_ok, want.ok);
        end
      end
      if (in_valid && !in_stall) begin
        result_q.push_back(step_tick(in_elapsed_ms, in_pressed_levels,
                                     in_take_short, in_take_long));
      end
    end
    open_beats <= result_q.size();
  end

endmodule

// ===== bench/tb_button_short_long_press_detector_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Press detector testbench
// Drives button ticks and register writes into the detector, with random
// gaps on the tick side and random back-pressure on the result side. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_button_short_long_press_detector_core;
  import bsl_pkg::*;

  localparam int HOLD_CYCLES = 64;
  localparam int QUIET_LIMIT = 3000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  ms_t               in_elapsed_ms = '0;
  fmask_t            in_pressed_levels = '0;
  logic              in_take_short = 1'b0;
  logic              in_take_long = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  fmask_t            out_short_mask;
  fmask_t            out_long_mask;
  logic              out_tick_ok;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index = CFG_SHORT_MS;
  ms_t               cfg_data = '0;

  int fail_count;
  int open_beats;
  int applied_ticks = 0;
  int quiet_cycles = 0;
  bit sender_gaps = 1'b1;
  bit calm = 1'b0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  button_short_long_press_detector_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_elapsed_ms(in_elapsed_ms), .in_pressed_levels(in_pressed_levels),
    .in_take_short(in_take_short), .in_take_long(in_take_long),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_short_mask(out_short_mask), .out_long_mask(out_long_mask),
    .out_tick_ok(out_tick_ok),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  press_event_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_elapsed_ms(in_elapsed_ms), .in_pressed_levels(in_pressed_levels),
    .in_take_short(in_take_short), .in_take_long(in_take_long),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_short_mask(out_short_mask), .out_long_mask(out_long_mask),
    .out_tick_ok(out_tick_ok),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .open_beats(open_beats)
  );

  // Result side back-pressure; one long hold-off lets the block fill up.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic ms_t rand_elapsed();
    case ($urandom_range(0, 15))
      0: return ms_t'($urandom_range(500, 65535));
      1: return '0;
      2: return 16'd499;
      default: return ms_t'($urandom_range(1, 200));
    endcase
  endfunction

  function automatic logic rand_take();
    return ($urandom_range(0, 3) == 0);
  endfunction

  task automatic send_tick(input ms_t el, input fmask_t lv, input logic ts,
                           input logic tl);
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_elapsed_ms     <= el;
    in_pressed_levels <= lv;
    in_take_short     <= ts;
    in_take_long      <= tl;
    do @(posedge clk); while (in_stall);
    if (el < SKIP_LIMIT) begin
      applied_ticks++;
    end
  endtask

  task automatic cfg_beat(input cfg_idx_t idx, input ms_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Registers change only once every outstanding result has come back.
  task automatic load_setting(input ms_t sh, input ms_t lg, input ms_t rl,
                              input fmask_t se, input fmask_t le);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (open_beats == 0);
    @(posedge clk);
    cfg_beat(CFG_SHORT_MS, sh);
    cfg_beat(CFG_LONG_MS, lg);
    cfg_beat(CFG_RELEASE_MS, rl);
    cfg_beat(CFG_SHORT_EN, ms_t'(se));
    cfg_beat(CFG_LONG_EN, ms_t'(le));
    cfg_valid <= 1'b0;
  endtask

  // Mostly press-then-release episodes on random buttons, with some noise.
  task automatic press_episodes(input int n);
    int     target;
    fmask_t held;
    target = applied_ticks + n;
    while (applied_ticks < target) begin
      if ($urandom_range(0, 6) == 0) begin
        send_tick(ms_t'($urandom), fmask_t'($urandom), rand_take(), rand_take());
      end else begin
        held = fmask_t'($urandom_range(1, 31));
        repeat ($urandom_range(1, 6)) begin
          send_tick(rand_elapsed(), held, rand_take(), rand_take());
        end
        repeat ($urandom_range(1, 4)) begin
          send_tick(rand_elapsed(),
                    ($urandom_range(0, 3) == 0) ? fmask_t'($urandom) : '0,
                    rand_take(), rand_take());
        end
      end
    end
  endtask

  // Long runs with near-maximum ticks drive the counters into saturation.
  task automatic hold_run(input int n, input fmask_t fixed, input fmask_t level);
    repeat (n) begin
      send_tick(ms_t'($urandom_range(490, 499)),
                (fmask_t'($urandom) & ~fixed) | (level & fixed),
                rand_take(), rand_take());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset thresholds: release, long hold, short tap, skipped ticks.
    send_tick(16'd0, 5'b00000, 1'b0, 1'b0);
    send_tick(16'd499, 5'b00000, 1'b0, 1'b0);
    send_tick(16'd499, 5'b00000, 1'b0, 1'b0);
    send_tick(16'd499, 5'b11111, 1'b0, 1'b0);
    send_tick(16'd499, 5'b11111, 1'b0, 1'b0);
    send_tick(16'd499, 5'b11111, 1'b0, 1'b0);
    send_tick(16'd499, 5'b11111, 1'b0, 1'b1);
    send_tick(16'd500, 5'b11111, 1'b1, 1'b1);
    send_tick(16'd65535, 5'b00000, 1'b1, 1'b0);
    send_tick(16'd100, 5'b00000, 1'b0, 1'b0);
    send_tick(16'd100, 5'b00000, 1'b1, 1'b0);
    send_tick(16'd60, 5'b10101, 1'b0, 1'b0);
    send_tick(16'd0, 5'b10101, 1'b0, 1'b0);
    send_tick(16'd50, 5'b00000, 1'b0, 1'b0);
    send_tick(16'd10, 5'b00000, 1'b1, 1'b1);
    send_tick(16'd50, 5'b01010, 1'b0, 1'b0);
    send_tick(16'd50, 5'b00000, 1'b0, 1'b0);
    send_tick(16'd1, 5'b00000, 1'b1, 1'b0);
    send_tick(16'h5555, 5'b01010, 1'b0, 1'b1);
    send_tick(16'hAAAA, 5'b10101, 1'b1, 1'b1);

    load_setting(16'd20, 16'd200, 16'd30, 5'b11111, 5'b11111);
    hold_go     = 1'b1;
    sender_gaps = 1'b0;
    press_episodes(30);
    sender_gaps = 1'b1;
    press_episodes(60);

    load_setting(16'd0, 16'd0, 16'd0, 5'b11111, 5'b11111);
    press_episodes(30);
    load_setting(16'd0, 16'd0, 16'd0, 5'b00000, 5'b00000);
    press_episodes(20);

    load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 5'b11111, 5'b11111);
    hold_run(136, 5'b00111, 5'b00000);
    hold_run(136, 5'b00111, 5'b00111);
    hold_run(4, 5'b00111, 5'b00000);

    load_setting(16'd10, 16'd120, 16'd20, fmask_t'($urandom), fmask_t'($urandom));
    press_episodes(60);

    load_setting(16'd25, 16'd300, 16'd15, fmask_t'($urandom), fmask_t'($urandom));
    calm        = 1'b1;
    sender_gaps = 1'b0;
    press_episodes(40);

    in_valid <= 1'b0;
    @(posedge clk);
    wait (open_beats == 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && open_beats == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
